[src/salts_pkg.sv]
// Package for the set-associative LRU tag store: MESI codes, request modes, FSM states
// and the request and result words. Depends on nothing; the controller, datapath, top level and testbench import it.
package salts_pkg;

  localparam int unsigned TAG_OUT_W = 36;

  typedef enum logic [1:0] {
    MODE_PROBE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_FILL  = 2'd2,
    MODE_WRITE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    MESI_M = 2'd0,
    MESI_E = 2'd1,
    MESI_S = 2'd2,
    MESI_I = 2'd3
  } mesi_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_UPD,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic look;
    logic update;
    logic clear;
  } ctl_cmd_t;

  // Request word, fields in channel order.
  typedef struct packed {
    mode_t       mode;
    logic [47:0] address;
    mesi_t       fill_state;
  } req_t;

  // Result word, fields in channel order.
  typedef struct packed {
    logic                 success;
    mesi_t                line_state;
    logic                 evicted;
    logic [TAG_OUT_W-1:0] evicted_tag;
    logic                 evicted_dirty;
  } rsp_t;

endpackage

[src/salts_if.sv]
// Valid/ready channel interface carrying one payload word per handshake.
// Depends on nothing but its type parameter.
interface salts_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/salts_ctrl.sv]
// Controller FSM of the tag store: sequences clearing, capture, lookup, update and output.
// Depends on salts_pkg.
module salts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                clr_done,
  output salts_pkg::ctl_cmd_t cmd
);
  import salts_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end
endmodule

[src/salts_dp.sv]
// Datapath of the tag store: set memory, way compare, victim choice and LRU update.
// Depends on salts_pkg.
module salts_dp #(
  parameter int SETS       = 64,
  parameter int WAYS       = 8,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_W     = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  salts_pkg::ctl_cmd_t cmd,
  input  salts_pkg::req_t     in_req,
  output logic                clr_done,
  output salts_pkg::rsp_t     res
);
  import salts_pkg::*;

  localparam int OFF_BITS = $clog2(LINE_BYTES + 1) - 1;
  localparam int SET_BITS = $clog2(SETS + 1) - 1;
  localparam int SHIFT    = OFF_BITS + SET_BITS;
  localparam int TAG_BITS = (ADDR_W > SHIFT) ? ADDR_W - SHIFT : 0;
  localparam int TW       = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam int SW       = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int RW       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WW       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AW       = (ADDR_W < 48) ? ADDR_W : 48;

  typedef struct packed {
    logic          valid;
    logic [TW-1:0] tag;
    mesi_t         mesi;
    logic          dirty;
    logic [RW-1:0] rank;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  // One row per set. Valid bits live in the rows; a clearing pass after reset
  // writes zero rows, one set per cycle.
  row_t          mem [SETS];
  logic [SW-1:0] clr_cnt_r;

  mode_t         mode_r;
  mesi_t         fstate_r;
  logic [SW-1:0] set_r;
  logic [TW-1:0] tag_r;
  row_t          row_r;
  row_t          row_nxt;

  logic [47:0] addr_m;
  assign addr_m = in_req.address & ((AW == 48) ? {48{1'b1}} : ((48'd1 << AW) - 48'd1));

  assign clr_done = (clr_cnt_r == SW'(SETS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_req.mode;
      fstate_r <= in_req.fill_state;
      set_r    <= (SET_BITS > 0) ? SW'(addr_m >> OFF_BITS) : '0;
      tag_r    <= (TAG_BITS > 0) ? TW'(addr_m >> SHIFT) : '0;
    end
  end

  // Registered row read.
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      row_r <= mem[set_r];
    end
  end

  // Lookup and decision.
  logic            hit, found;
  logic [WW-1:0]   hway, fway, vway, way;
  logic [RW-1:0]   best;
  always_comb begin
    hit = 1'b0; hway = '0; found = 1'b0; fway = '0; vway = '0; best = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_r[w].valid && row_r[w].tag == tag_r) begin
        hit = 1'b1; hway = WW'(w);
      end
      if (!row_r[w].valid) begin
        found = 1'b1; fway = WW'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (w == 0 || row_r[w].rank > best) begin
        best = row_r[w].rank; vway = WW'(w);
      end
    end
    way = hit ? hway : (found ? fway : vway);
  end

  logic fill, rd_hit, wr_ok, doit, ev;
  assign fill   = (mode_r == MODE_FILL);
  assign rd_hit = (mode_r == MODE_READ) && hit;
  assign wr_ok  = (mode_r == MODE_WRITE) && hit &&
                  (row_r[hway].mesi == MESI_M || row_r[hway].mesi == MESI_E);
  assign ev     = fill && !hit && !found;
  assign doit   = fill || rd_hit;

  logic [RW:0] old;
  assign old = (fill && !hit) ? (RW + 1)'(WAYS) : {1'b0, row_r[way].rank};

  // New contents of the addressed row.
  always_comb begin
    row_nxt = row_r;
    for (int w = 0; w < WAYS; w++) begin
      if (doit) begin
        if (WW'(w) == way) begin
          row_nxt[w].rank = '0;
        end else if (row_r[w].valid && {1'b0, row_r[w].rank} < old) begin
          row_nxt[w].rank = row_r[w].rank + 1'b1;
        end
      end
      if (WW'(w) == way && fill) begin
        row_nxt[w].valid = 1'b1;
        row_nxt[w].tag   = tag_r;
        row_nxt[w].mesi  = fstate_r;
        row_nxt[w].dirty = 1'b0;
      end
      if (WW'(w) == way && wr_ok) begin
        row_nxt[w].mesi  = MESI_M;
        row_nxt[w].dirty = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.update) begin
      mem[set_r] <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res.evicted       <= ev;
      res.evicted_tag   <= ev ? TAG_OUT_W'(row_r[vway].tag) : '0;
      res.evicted_dirty <= ev && row_r[vway].dirty;
      if (fill) begin
        res.success <= 1'b1; res.line_state <= fstate_r;
      end else if (mode_r == MODE_WRITE) begin
        res.success    <= wr_ok;
        res.line_state <= wr_ok ? MESI_M : (hit ? row_r[hway].mesi : MESI_I);
      end else begin
        res.success    <= hit;
        res.line_state <= hit ? row_r[hway].mesi : MESI_I;
      end
    end
  end
endmodule

[src/set_assoc_lru_tag_store.sv]
// Top level of the set-associative tag store with true LRU and MESI state.
// Depends on salts_pkg, salts_if, salts_ctrl and salts_dp.
//
//  Channel | Dir | Word fields
//  in_ch   | in  | mode, address, fill_state
//  out_ch  | out | success, line_state, evicted, evicted_tag, evicted_dirty
//
// Each word passes through four steps: capture, registered read of the set row,
// compare and write-back of the row, and the result hold state. The single
// port of the set memory sets that order, and no new word is taken until the
// result has been taken. After reset a clearing pass writes one zero row per
// cycle, so all SETS rows (64 by default) are cleared before the first word is
// taken. A stalled result holds in its register until out_ch.ready is seen.
module set_assoc_lru_tag_store #(
  parameter int SETS       = 64,
  parameter int WAYS       = 8,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_W     = 48
) (
  input logic clk,
  input logic rst_n,
  salts_if.sink   in_ch,
  salts_if.source out_ch
);
  import salts_pkg::*;

  ctl_cmd_t cmd;
  logic     clr_done;

  salts_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .clr_done,
    .cmd
  );

  salts_dp #(.SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES), .ADDR_W(ADDR_W)) u_dp (
    .clk, .rst_n, .cmd,
    .in_req  (in_ch.data),
    .clr_done,
    .res     (out_ch.data)
  );
endmodule

[src/salts_chk.sv]
// Port-level checker for the tag store, bound to the top level.
// Depends on the top level's ports only.
module salts_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        success,
  input logic        evicted,
  input logic [35:0] evicted_tag,
  input logic        evicted_dirty
);
  // One word in flight: no input taken while a result is shown.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input taken while result pending");
  // Eviction only comes with success.
  a_ev: assert property (@(posedge clk) disable iff (!rst_n) out_valid && evicted |-> success)
    else $error("eviction without success");
  a_evt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !evicted |-> evicted_tag == '0 && !evicted_dirty)
    else $error("eviction fields set without eviction");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(evicted_tag))
    else $error("stalled result changed");
endmodule

bind set_assoc_lru_tag_store salts_chk u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .success(out_ch.data.success), .evicted(out_ch.data.evicted),
  .evicted_tag(out_ch.data.evicted_tag), .evicted_dirty(out_ch.data.evicted_dirty)
);

[tb/tb.sv]
// Testbench for set_assoc_lru_tag_store: directed and random requests on in_ch,
// with every result word on out_ch checked against a predictor kept in a scoreboard class.
// Depends on salts_pkg, salts_if and the set_assoc_lru_tag_store RTL.
module tb;
  import salts_pkg::*;

  localparam int SETS       = 64;
  localparam int WAYS       = 8;
  localparam int LINE_BYTES = 64;
  localparam int ADDR_W     = 48;
  localparam int OFF_W      = $clog2(LINE_BYTES);
  localparam int SET_W      = $clog2(SETS);
  localparam int TAG_W      = ADDR_W - OFF_W - SET_W;
  localparam int N_RANDOM   = 1430;
  localparam int IDLE_LIMIT = 2000;

  // The scoreboard holds its own copy of the tag array. Each accepted request is
  // applied to that copy at once, which is sound because the block answers in order.
  class tag_store_scoreboard;
    bit                   line_ok   [SETS*WAYS];
    logic [TAG_W-1:0]     line_tag  [SETS*WAYS];
    mesi_t                line_mesi [SETS*WAYS];
    bit                   line_dirty[SETS*WAYS];
    int unsigned          line_age  [SETS*WAYS];
    rsp_t                 pending_rsp[$];
    int unsigned          mismatches;

    function new();
      foreach (line_ok[i]) line_ok[i] = 0;
      mismatches = 0;
    endfunction

    // Make way w the most recent of its set; younger lines age by one.
    function void make_recent(int unsigned base, int unsigned w);
      int unsigned old_age;
      old_age = line_ok[base+w] ? line_age[base+w] : WAYS;
      for (int i = 0; i < WAYS; i++) begin
        if (i != w && line_ok[base+i] && line_age[base+i] < old_age) begin
          line_age[base+i]++;
        end
      end
      line_age[base+w] = 0;
    endfunction

    function void note_request(req_t rq);
      int unsigned      set_idx, base, way, oldest;
      logic [TAG_W-1:0] tag;
      bit               hit, free_found;
      rsp_t             r;
      set_idx = rq.address[OFF_W +: SET_W];
      tag     = rq.address[OFF_W+SET_W +: TAG_W];
      base    = set_idx * WAYS;
      way     = 0;
      hit     = 0;
      r       = '0;
      r.line_state = MESI_I;
      for (int i = 0; i < WAYS; i++) begin
        if (!hit && line_ok[base+i] && line_tag[base+i] == tag) begin
          hit = 1;
          way = i;
        end
      end
      case (rq.mode)
        MODE_PROBE, MODE_READ: begin
          if (hit) begin
            r.success    = 1;
            r.line_state = line_mesi[base+way];
            if (rq.mode == MODE_READ) make_recent(base, way);
          end
        end
        MODE_FILL: begin
          if (!hit) begin
            free_found = 0;
            for (int i = 0; i < WAYS; i++) begin
              if (!free_found && !line_ok[base+i]) begin
                free_found = 1;
                way = i;
              end
            end
            // Full set: the oldest line goes, lowest way on a tie.
            if (!free_found) begin
              oldest = line_age[base];
              way    = 0;
              for (int i = 1; i < WAYS; i++) begin
                if (line_age[base+i] > oldest) begin
                  oldest = line_age[base+i];
                  way    = i;
                end
              end
              r.evicted       = 1;
              r.evicted_tag   = TAG_OUT_W'(line_tag[base+way]);
              r.evicted_dirty = line_dirty[base+way];
              line_ok[base+way] = 0;
            end
            line_tag[base+way] = tag;
          end
          make_recent(base, way);
          line_ok[base+way]    = 1;
          line_mesi[base+way]  = rq.fill_state;
          line_dirty[base+way] = 0;
          r.success    = 1;
          r.line_state = rq.fill_state;
        end
        default: begin
          if (hit) begin
            if (line_mesi[base+way] == MESI_M || line_mesi[base+way] == MESI_E) begin
              line_mesi[base+way]  = MESI_M;
              line_dirty[base+way] = 1;
              r.success = 1;
            end
            r.line_state = line_mesi[base+way];
          end
        end
      endcase
      pending_rsp.insert(pending_rsp.size(), r);
    endfunction

    function void report(string what, rsp_t got, rsp_t want);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected ok=%0d st=%0d ev=%0d tag=%h dirty=%0d,",
                 what, want.success, want.line_state, want.evicted, want.evicted_tag,
                 want.evicted_dirty);
        $display("  got ok=%0d st=%0d ev=%0d tag=%h dirty=%0d",
                 got.success, got.line_state, got.evicted, got.evicted_tag,
                 got.evicted_dirty);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report("unexpected result word", got, '0);
        return;
      end
      want = pending_rsp[0];
      pending_rsp.delete(0);
      if (got !== want) report("result word mismatch", got, want);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;

  salts_if #(.T(req_t)) in_ch ();
  salts_if #(.T(rsp_t)) out_ch ();

  set_assoc_lru_tag_store #(
    .SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES), .ADDR_W(ADDR_W)
  ) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  tag_store_scoreboard tracker = new();
  int unsigned idle_cycles = 0;

  initial begin
    in_ch.valid  = 0;
    in_ch.data   = '0;
    out_ch.ready = 0;
  end

  always #2 clk = ~clk;

  // Handshakes are judged at the falling edge, where valid and ready are settled
  // for the rising edge that follows. The watchdog counts cycles with no transfer.
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Send one request word after a random gap and return at the edge that takes it.
  task automatic send_request(mode_t m, logic [47:0] a, mesi_t fs);
    int unsigned gap;
    req_t        rq;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    rq.mode       = m;
    rq.address    = a;
    rq.fill_state = fs;
    in_ch.valid <= 1;
    in_ch.data  <= rq;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    tracker.note_request(rq);
  endtask

  function automatic logic [47:0] make_addr(int unsigned set_idx, logic [TAG_W-1:0] tag);
    logic [OFF_W-1:0] off;
    off = OFF_W'($urandom);
    return {tag, SET_W'(set_idx), off};
  endfunction

  // Result side: a random stall before each word, then take it.
  initial begin
    rsp_t got;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int unsigned stall;
      stall = $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(negedge clk);
      while (!out_ch.valid) @(negedge clk);
      got = out_ch.data;
      @(posedge clk);
      tracker.check_result(got);
    end
  end

  initial begin
    logic [TAG_W-1:0] t;
    int unsigned      pick, s;
    mode_t            m;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part. Set 63 with the all-ones tag and set 0 with tag zero cover
    // the field extremes; a probe first hits an empty set.
    send_request(MODE_PROBE, 48'hFFFF_FFFF_FFFF, MESI_I);
    send_request(MODE_FILL,  48'hFFFF_FFFF_FFFF, MESI_E);
    send_request(MODE_PROBE, 48'hFFFF_FFFF_FFC0, MESI_M);
    send_request(MODE_WRITE, 48'hFFFF_FFFF_FFFF, MESI_S);
    send_request(MODE_FILL,  48'h0000_0000_0000, MESI_S);
    send_request(MODE_WRITE, 48'h0000_0000_0000, MESI_M);  // denied on a shared line
    send_request(MODE_WRITE, 48'h0000_0000_1000, MESI_M);  // write miss
    send_request(MODE_READ,  48'h0000_0000_0000, MESI_M);
    // Fill set 1 with nine tags so the oldest line goes out; make the first one
    // dirty and read the second so the eviction order is not plain fill order.
    for (int i = 0; i < 9; i++) begin
      send_request(MODE_FILL, make_addr(1, TAG_W'(i + 1)), mesi_t'(i % 2));
      if (i == 0) send_request(MODE_WRITE, make_addr(1, 1), MESI_M);
      if (i == 7) send_request(MODE_READ, make_addr(1, 2), MESI_M);
    end
    // Refill of a present, clean tag in the invalid state; a probe of it still hits.
    send_request(MODE_FILL,  make_addr(1, 3), MESI_I);
    send_request(MODE_PROBE, make_addr(1, 3), MESI_M);
    send_request(MODE_FILL,  make_addr(1, 10), MESI_M);

    // Random part: mostly a few busy sets and a small tag pool so that hits,
    // refills and evictions are common, with fully random addresses mixed in.
    for (int n = 0; n < N_RANDOM; n++) begin
      // Hold off once until every result has come back.
      if (n == N_RANDOM / 2) begin
        in_ch.valid <= 0;
        @(posedge clk);
        while (tracker.pending_rsp.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) m = MODE_FILL;
      else if (pick < 60) m = MODE_READ;
      else if (pick < 75) m = MODE_PROBE;
      else m = MODE_WRITE;
      if ($urandom_range(0, 9) == 0) begin
        send_request(m, 48'({$urandom, $urandom}), mesi_t'($urandom_range(0, 3)));
      end else begin
        s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SETS - 1) : $urandom_range(0, 3);
        t = TAG_W'($urandom_range(0, 11));
        if ($urandom_range(0, 3) == 0) t = ~t;
        send_request(m, make_addr(s, t), mesi_t'($urandom_range(0, 3)));
      end
    end
    in_ch.valid <= 0;

    // Drain, then wait for any stray word.
    while (tracker.pending_rsp.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[sim.f]
src/salts_pkg.sv
src/salts_if.sv
src/salts_ctrl.sv
src/salts_dp.sv
src/set_assoc_lru_tag_store.sv
src/salts_chk.sv
tb/tb.sv
